/* rtl/asmp_pkg.sv */
// ----------------------------------------------------------------------------
// asmp_pkg
// Types and codes shared by the static metadata parser modules.
// ----------------------------------------------------------------------------
package asmp_pkg;

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_MODE    = 3'd1,
    PH_AMBI    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_LAYER   = 3'd4,
    PH_GAIN    = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_AMBI_CFG  = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd2;
  localparam logic [2:0] KIND_LAYER_CFG = 3'd3;
  localparam logic [2:0] KIND_GAIN      = 3'd4;
  localparam logic [2:0] KIND_TRUNC     = 3'd5;

  localparam int PayW = 18;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         layer_index;
    logic [7:0]         value_a;
    logic [7:0]         value_b;
    logic [7:0]         value_c;
    logic               flag_a;
    logic               flag_b;
    logic signed [15:0] word;
    logic               block_done;
  } out_t;

  typedef struct packed {
    phase_t          phase;
    logic [2:0]      byte_in_record;
    logic [PayW-1:0] payload_remaining;
    logic [1:0]      ambi_mode;
    logic [2:0]      layers_total;
    logic [2:0]      layer_now;
    logic [3:0][7:0] held_bytes;
    logic            gain_present_hold;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:             PH_VERSION,
    byte_in_record:    3'd0,
    payload_remaining: '0,
    ambi_mode:         2'd0,
    layers_total:      3'd0,
    layer_now:         3'd0,
    held_bytes:        '0,
    gain_present_hold: 1'b0
  };

endpackage

/* rtl/audio_static_metadata_parser.sv */
// ----------------------------------------------------------------------------
// audio_static_metadata_parser
// Byte-serial parser for an immersive-audio static metadata block.
// ----------------------------------------------------------------------------
// One metadata byte is taken every clock cycle while src_stall is low. A byte
// that completes a record (header, ambisonics config, payload byte, layer
// config, layer gain or a truncation marker) puts that record into the result
// register, or into the one-entry skid buffer while the result register holds
// a record not being taken, so the byte side keeps running while one record
// waits; src_stall rises only when both hold a record that has not been taken.
module audio_static_metadata_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_stall,
  input  asmp_pkg::in_t   src_item,
  output logic            res_valid,
  input  logic            res_stall,
  output asmp_pkg::out_t  res_item
);
  import asmp_pkg::*;

  state_t st;
  state_t st_next;
  out_t   rec;
  logic   rec_have;
  out_t   skid_item;
  logic   skid_valid;
  logic   accept;
  logic   push;
  logic   res_take;

  asmp_step u_step (
    .st       (st),
    .item     (src_item),
    .st_next  (st_next),
    .rec      (rec),
    .rec_have (rec_have)
  );

  assign src_stall = skid_valid;
  assign accept    = src_valid && !skid_valid;
  assign push      = accept && rec_have;
  assign res_take  = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || res_take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_take) begin
        res_item <= skid_item;
      end
    end else if (push) begin
      if (!res_valid || res_take) begin
        res_item <= rec;
      end else begin
        skid_item <= rec;
      end
    end
  end

  // skid only fills behind a waiting result
  a_skid_behind_res : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid buffer holds a record with no result pending");

  // end of block always returns the parser to the version byte
  a_eob_restart : assert property (@(posedge clk) disable iff (rst)
    (accept && src_item.end_of_block) |=> (st.phase == PH_VERSION))
    else $error("parser did not restart after end of block");

  a_layer_bound : assert property (@(posedge clk) disable iff (rst)
    st.layer_now <= st.layers_total)
    else $error("layer counter passed the layer count");

  a_payload_nonzero : assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_PAYLOAD) |-> (st.payload_remaining != '0))
    else $error("payload phase with nothing left to pass");

  // a block-ending record always leaves the parser done or restarted
  a_done_record : assert property (@(posedge clk) disable iff (rst)
    (push && rec.block_done) |=> (st.phase == PH_DONE || st.phase == PH_VERSION))
    else $error("block_done record while parsing continues");

endmodule

/* rtl/asmp_step.sv */
// ----------------------------------------------------------------------------
// asmp_step
// Per-byte transition of the parser state and the record that the byte makes.
// ----------------------------------------------------------------------------
module asmp_step (
  input  asmp_pkg::state_t st,
  input  asmp_pkg::in_t    item,
  output asmp_pkg::state_t st_next,
  output asmp_pkg::out_t   rec,
  output logic             rec_have
);
  import asmp_pkg::*;

  state_t      adv;
  logic [7:0]  b;
  logic [8:0]  nm_sum;
  logic [16:0] nm_prod;
  logic [PayW-1:0] pay;
  logic [PayW-1:0] rem_dec;
  logic [2:0]  ln_inc;

  assign b       = item.data_byte;
  assign nm_sum  = {1'b0, st.held_bytes[1]} + {1'b0, b};
  assign nm_prod = nm_sum * st.held_bytes[0];
  assign rem_dec = (st.payload_remaining != '0) ? st.payload_remaining - 1'b1
                                                : st.payload_remaining;
  assign ln_inc  = st.layer_now + 3'd1;

  always_comb begin
    case (st.ambi_mode)
      2'd1:    pay = {{(PayW-8){1'b0}}, st.held_bytes[0]};
      2'd2:    pay = {nm_prod, 1'b0};
      default: pay = '0;
    endcase
  end

  // advanced state, before end of block is applied
  always_comb begin
    adv = st;
    case (st.phase)
      PH_VERSION: begin
        adv.phase = PH_MODE;
      end
      PH_MODE: begin
        adv.ambi_mode    = b[7:6];
        adv.layers_total = b[5:3];
        adv.byte_in_record = 3'd0;
        if (b[7:6] != 2'd0) begin
          adv.phase = PH_AMBI;
        end else begin
          adv.layer_now = 3'd0;
          adv.phase = (b[5:3] == 3'd0) ? PH_DONE : PH_LAYER;
        end
      end
      PH_AMBI: begin
        if (st.byte_in_record < 3'd2) begin
          adv.held_bytes[st.byte_in_record[1:0]] = b;
          adv.byte_in_record = st.byte_in_record + 3'd1;
        end else begin
          adv.payload_remaining = pay;
          adv.byte_in_record = 3'd0;
          if (pay != '0) begin
            adv.phase = PH_PAYLOAD;
          end else begin
            adv.layer_now = 3'd0;
            adv.phase = (st.layers_total == 3'd0) ? PH_DONE : PH_LAYER;
          end
        end
      end
      PH_PAYLOAD: begin
        adv.payload_remaining = rem_dec;
        if (rem_dec == '0) begin
          adv.layer_now = 3'd0;
          adv.byte_in_record = 3'd0;
          adv.phase = (st.layers_total == 3'd0) ? PH_DONE : PH_LAYER;
        end
      end
      PH_LAYER: begin
        if (st.byte_in_record < 3'd4) begin
          adv.held_bytes[st.byte_in_record[1:0]] = b;
          adv.byte_in_record = st.byte_in_record + 3'd1;
        end else if (st.held_bytes[0][3]) begin
          adv.gain_present_hold = 1'b1;
          adv.phase = PH_GAIN;
          adv.byte_in_record = 3'd0;
        end else begin
          adv.layer_now = ln_inc;
          adv.byte_in_record = 3'd0;
          adv.phase = (ln_inc >= st.layers_total) ? PH_DONE : PH_LAYER;
        end
      end
      PH_GAIN: begin
        if (st.byte_in_record < 3'd2) begin
          adv.held_bytes[st.byte_in_record[1:0]] = b;
          adv.byte_in_record = st.byte_in_record + 3'd1;
        end else begin
          adv.gain_present_hold = 1'b0;
          adv.layer_now = ln_inc;
          adv.byte_in_record = 3'd0;
          adv.phase = (ln_inc >= st.layers_total) ? PH_DONE : PH_LAYER;
        end
      end
      PH_DONE: begin
        adv = st;
      end
      default: begin
        adv = ST_RESET;
      end
    endcase
  end

  assign st_next = item.end_of_block ? ST_RESET : adv;

  // record for this byte
  always_comb begin
    rec      = '0;
    rec_have = 1'b0;
    case (st.phase)
      PH_MODE: begin
        rec.kind    = KIND_HEADER;
        rec.value_a = {6'd0, b[7:6]};
        rec.value_b = {5'd0, b[5:3]};
        rec_have    = 1'b1;
      end
      PH_AMBI: begin
        if (st.byte_in_record >= 3'd2) begin
          rec.kind    = KIND_AMBI_CFG;
          rec.value_a = st.held_bytes[0];
          rec.value_b = st.held_bytes[1];
          rec.value_c = b;
          rec_have    = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        rec.kind    = KIND_PAYLOAD;
        rec.value_a = b;
        rec_have    = 1'b1;
      end
      PH_LAYER: begin
        if (st.byte_in_record >= 3'd4) begin
          rec.kind        = KIND_LAYER_CFG;
          rec.layer_index = st.layer_now;
          rec.value_a     = {4'd0, st.held_bytes[0][7:4]};
          rec.flag_a      = st.held_bytes[0][3];
          rec.flag_b      = st.held_bytes[0][2];
          rec.value_b     = st.held_bytes[1];
          rec.value_c     = st.held_bytes[2];
          rec.word        = {st.held_bytes[3], b};
          rec_have        = 1'b1;
        end
      end
      PH_GAIN: begin
        if (st.byte_in_record >= 3'd2) begin
          rec.kind        = KIND_GAIN;
          rec.layer_index = st.layer_now;
          rec.value_a     = {2'd0, st.held_bytes[0][7:2]};
          rec.word        = {st.held_bytes[1], b};
          rec_have        = 1'b1;
        end
      end
      default: begin
        rec_have = 1'b0;
      end
    endcase

    if (st.phase != PH_DONE) begin
      if (item.end_of_block) begin
        // block ended before parsing finished
        if (adv.phase != PH_DONE) begin
          rec             = '0;
          rec.kind        = KIND_TRUNC;
          rec.layer_index = adv.layer_now;
        end
        rec.block_done = 1'b1;
        rec_have       = 1'b1;
      end else if (adv.phase == PH_DONE && rec_have) begin
        rec.block_done = 1'b1;
      end
    end
  end

endmodule

/* dv/metadata_record_checker.sv */
// ----------------------------------------------------------------------------
// metadata_record_checker
// Watches both channels of the static metadata parser. It runs its own copy
// of the parse state on every accepted byte, queues the record each byte
// should produce, and compares every accepted record with the oldest one.
// ----------------------------------------------------------------------------
module metadata_record_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  input  logic            src_stall,
  input  asmp_pkg::in_t   src_item,
  input  logic            res_valid,
  input  logic            res_stall,
  input  asmp_pkg::out_t  res_item,
  output logic [31:0]     fail_count,
  output logic [31:0]     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import asmp_pkg::*;

  phase_t           phase;
  logic [2:0]       rec_pos;
  logic [PayW-1:0]  payload_left;
  logic [1:0]       mode;
  logic [2:0]       layer_count;
  logic [2:0]       layer_cur;
  logic [7:0]       hold [4];

  out_t  expected_records [$];
  out_t  exp_rec;
  int    failures = 0;

  initial begin
    fail_count = '0;
    pending    = '0;
  end

  function automatic string rec_text(input out_t r);
    return $sformatf({"kind=%0d layer=%0d a=%02h b=%02h c=%02h",
                      " fa=%0b fb=%0b word=%04h done=%0b"},
                     r.kind, r.layer_index, r.value_a, r.value_b, r.value_c,
                     r.flag_a, r.flag_b, r.word, r.block_done);
  endfunction

  task automatic note_failure(input string msg);
    failures = failures + 1;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic clear_parser();
    phase        = PH_VERSION;
    rec_pos      = '0;
    payload_left = '0;
    mode         = '0;
    layer_count  = '0;
    layer_cur    = '0;
    for (int i = 0; i < 4; i++) hold[i] = '0;
  endtask

  task automatic enter_layers();
    layer_cur = '0;
    rec_pos   = '0;
    phase     = (layer_count == 3'd0) ? PH_DONE : PH_LAYER;
  endtask

  task automatic advance_layer();
    layer_cur = layer_cur + 3'd1;
    rec_pos   = '0;
    phase     = (layer_cur >= layer_count) ? PH_DONE : PH_LAYER;
  endtask

  // one metadata byte through the parse state; queues the record it completes
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    out_t            rec;
    logic            have;
    logic [PayW-1:0] plen;
    rec  = '0;
    have = 1'b0;
    if (phase == PH_DONE) begin
      // trailing bytes are dropped until the buffer ends
      if (eob) clear_parser();
    end else begin
      case (phase)
        PH_VERSION: begin
          phase = PH_MODE;
        end
        PH_MODE: begin
          mode        = b[7:6];
          layer_count = b[5:3];
          rec.kind    = KIND_HEADER;
          rec.value_a = {6'd0, b[7:6]};
          rec.value_b = {5'd0, b[5:3]};
          have        = 1'b1;
          if (mode != 2'd0) begin
            phase   = PH_AMBI;
            rec_pos = '0;
          end else begin
            enter_layers();
          end
        end
        PH_AMBI: begin
          if (rec_pos < 3'd2) begin
            hold[rec_pos[1:0]] = b;
            rec_pos = rec_pos + 3'd1;
          end else begin
            rec.kind    = KIND_AMBI_CFG;
            rec.value_a = hold[0];
            rec.value_b = hold[1];
            rec.value_c = b;
            have        = 1'b1;
            if (mode == 2'd1) plen = PayW'(hold[0]);
            else if (mode == 2'd2) plen = PayW'(2 * (hold[1] + b) * hold[0]);
            else plen = '0;
            payload_left = plen;
            rec_pos      = '0;
            if (plen != '0) phase = PH_PAYLOAD;
            else enter_layers();
          end
        end
        PH_PAYLOAD: begin
          rec.kind    = KIND_PAYLOAD;
          rec.value_a = b;
          have        = 1'b1;
          if (payload_left != '0) payload_left = payload_left - 1'b1;
          if (payload_left == '0) enter_layers();
        end
        PH_LAYER: begin
          if (rec_pos < 3'd4) begin
            hold[rec_pos[1:0]] = b;
            rec_pos = rec_pos + 3'd1;
          end else begin
            rec.kind        = KIND_LAYER_CFG;
            rec.layer_index = layer_cur;
            rec.value_a     = {4'd0, hold[0][7:4]};
            rec.flag_a      = hold[0][3];
            rec.flag_b      = hold[0][2];
            rec.value_b     = hold[1];
            rec.value_c     = hold[2];
            rec.word        = {hold[3], b};
            have            = 1'b1;
            if (hold[0][3]) begin
              phase   = PH_GAIN;
              rec_pos = '0;
            end else begin
              advance_layer();
            end
          end
        end
        PH_GAIN: begin
          if (rec_pos < 3'd2) begin
            hold[rec_pos[1:0]] = b;
            rec_pos = rec_pos + 3'd1;
          end else begin
            rec.kind        = KIND_GAIN;
            rec.layer_index = layer_cur;
            rec.value_a     = {2'd0, hold[0][7:2]};
            rec.word        = {hold[1], b};
            have            = 1'b1;
            advance_layer();
          end
        end
        default: begin
          clear_parser();
        end
      endcase

      if (eob) begin
        // buffer ended before the block did
        if (phase != PH_DONE) begin
          rec             = '0;
          rec.kind        = KIND_TRUNC;
          rec.layer_index = layer_cur;
          have            = 1'b1;
        end
        rec.block_done = 1'b1;
        clear_parser();
      end else if (phase == PH_DONE && have) begin
        rec.block_done = 1'b1;
      end

      if (have) expected_records.push_back(rec);
    end
  endtask

  // records are registered before they leave, so compare before predicting
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_records.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_records.size() == 0) begin
          note_failure({"unexpected record: ", rec_text(res_item)});
        end else begin
          exp_rec = expected_records.pop_front();
          if (res_item.kind !== exp_rec.kind ||
              res_item.layer_index !== exp_rec.layer_index ||
              res_item.value_a !== exp_rec.value_a ||
              res_item.value_b !== exp_rec.value_b ||
              res_item.value_c !== exp_rec.value_c ||
              res_item.flag_a !== exp_rec.flag_a ||
              res_item.flag_b !== exp_rec.flag_b ||
              res_item.word !== exp_rec.word ||
              res_item.block_done !== exp_rec.block_done) begin
            note_failure({"record mismatch\n  expected ", rec_text(exp_rec),
                          "\n  actual   ", rec_text(res_item)});
          end
        end
      end
      if (src_valid && !src_stall) parse_byte(src_item.data_byte, src_item.end_of_block);
    end
    fail_count <= failures;
    pending    <= expected_records.size();
  end

endmodule

/* dv/tb_audio_static_metadata_parser.sv */
// ----------------------------------------------------------------------------
// tb_audio_static_metadata_parser
// Feeds the static metadata parser a few hand-built blocks, then random
// well-formed blocks mixed with cut-short blocks and noise, with random gaps
// and stalls on both sides. The checker beside the block judges the records.
// ----------------------------------------------------------------------------
module tb_audio_static_metadata_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import asmp_pkg::*;

  localparam int ItemTarget  = 2000;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 16;
  localparam int NoCut       = 1 << 30;

  logic         clk;
  logic         rst;
  logic         src_valid;
  logic         src_stall;
  in_t          src_item;
  logic         res_valid;
  logic         res_stall;
  out_t         res_item;
  logic [31:0]  fail_count;
  logic [31:0]  pending;

  in_t  block_bytes [$];
  int   cut_at = NoCut;
  int   useful_sent = 0;
  int   src_style = 0;
  int   idle_cycles = 0;
  int   rcv_style;
  int   rcv_hold;
  int   rcv_r;

  audio_static_metadata_parser dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  metadata_record_checker records (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic add_byte(input logic [7:0] b, input logic eob);
    in_t w;
    if (block_bytes.size() < cut_at) begin
      w.data_byte    = b;
      w.end_of_block = eob;
      block_bytes.push_back(w);
    end
  endtask

  task automatic mark_last_eob();
    in_t w;
    w = block_bytes.pop_back();
    w.end_of_block = 1'b1;
    block_bytes.push_back(w);
  endtask

  task automatic send_block();
    int gap;
    int r;
    foreach (block_bytes[i]) begin
      r = $urandom_range(0, 99);
      case (src_style)
        1: gap = (r < 75) ? 0 : 1;
        2: gap = (r < 50) ? 0 : $urandom_range(1, 3);
        3: gap = (r < 80) ? 0 : ((r < 95) ? $urandom_range(1, 4) : $urandom_range(8, 30));
        default: gap = 0;
      endcase
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      src_valid <= 1'b1;
      src_item  <= block_bytes[i];
      do @(posedge clk); while (src_stall);
    end
  endtask

  task automatic build_random_block();
    int         r;
    int         cnt;
    int         plen;
    logic       broken;
    logic [1:0] mode;
    logic [2:0] layers;
    logic [2:0] rsv;
    logic [7:0] c;
    logic [7:0] n;
    logic [7:0] m;
    logic [7:0] b0;
    block_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // noise: random words with scattered end-of-block marks
      cut_at = NoCut;
      cnt = $urandom_range(1, 12);
      repeat (cnt) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      mark_last_eob();
      useful_sent += block_bytes.size();
    end else begin
      broken = (r >= 88);
      cut_at = broken ? $urandom_range(1, 40) : NoCut;
      mode   = 2'($urandom_range(0, 3));
      layers = 3'($urandom_range(0, 7));
      rsv    = 3'($urandom_range(0, 7));
      add_byte(8'($urandom_range(0, 255)), 1'b0);
      add_byte({mode, layers, rsv}, 1'b0);
      if (mode != 2'd0) begin
        if (mode == 2'd2 && !broken) begin
          c = 8'($urandom_range(0, 3));
          n = 8'($urandom_range(0, 3));
          m = 8'($urandom_range(0, 3));
        end else begin
          c = 8'(($urandom_range(0, 24) == 0 || broken) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, 6));
          n = 8'($urandom_range(0, 255));
          m = 8'($urandom_range(0, 255));
        end
        add_byte(c, 1'b0);
        add_byte(n, 1'b0);
        add_byte(m, 1'b0);
        plen = (mode == 2'd1) ? int'(c) : ((mode == 2'd2) ? 2 * (n + m) * c : 0);
        for (int i = 0; i < plen && block_bytes.size() < cut_at; i++)
          add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      for (int i = 0; i < layers; i++) begin
        b0 = 8'($urandom_range(0, 255));
        add_byte(b0, 1'b0);
        repeat (4) add_byte(8'($urandom_range(0, 255)), 1'b0);
        if (b0[3]) repeat (3) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      useful_sent += block_bytes.size();
      if (broken || $urandom_range(0, 1)) begin
        mark_last_eob();
      end else begin
        // trailing words the parser drops, then the end of the buffer
        cnt = $urandom_range(0, 3);
        repeat (cnt) add_byte(8'($urandom_range(0, 255)), 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_item  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed blocks go out back to back; the result side starts out held off
    src_style = 0;
    cut_at    = NoCut;

    // mode 0 without layers: header ends the block, later words dropped
    block_bytes.delete();
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hAB, 1'b0);
    add_byte(8'h00, 1'b1);
    send_block();

    // one layer with output gain, buffer ends on the completing word
    block_bytes.delete();
    add_byte(8'h00, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte(8'hFC, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hFF, 1'b1);
    send_block();

    // mode 3 with seven layers, cut inside the first layer config
    block_bytes.delete();
    add_byte(8'h5A, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b1);
    send_block();

    // buffer ends on the version word
    block_bytes.delete();
    add_byte(8'h00, 1'b1);
    send_block();

    // mode 2 with the largest demixing matrix, cut after two payload words
    block_bytes.delete();
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    send_block();

    while (useful_sent < ItemTarget) begin
      src_style = $urandom_range(0, 3);
      build_random_block();
      send_block();
    end
    src_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    res_stall <= 1'b0;
    do @(posedge clk); while (rst);
    // long hold-off so both record slots fill and the byte side stalls
    res_stall <= 1'b1;
    repeat (80) @(posedge clk);
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      rcv_style = $urandom_range(0, 3);
      repeat ($urandom_range(4, 30)) begin
        rcv_r = $urandom_range(0, 99);
        case (rcv_style)
          1: rcv_hold = (rcv_r < 70) ? 0 : 1;
          2: rcv_hold = (rcv_r < 40) ? 0 : $urandom_range(1, 3);
          3: rcv_hold = (rcv_r < 85) ? 0 :
                        ((rcv_r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30));
          default: rcv_hold = 0;
        endcase
        if (rcv_hold > 0) begin
          res_stall <= 1'b1;
          repeat (rcv_hold) @(posedge clk);
        end
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(60, 100)) @(posedge clk);
        res_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles in a row with no word moving on either side
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/asmp_pkg.sv
rtl/asmp_step.sv
rtl/audio_static_metadata_parser.sv
dv/metadata_record_checker.sv
dv/tb_audio_static_metadata_parser.sv
